// ===== rtl/csv_record_tokenizer_unit_macros.svh =====
// Assertion macros shared by the CSV tokenizer RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef CSV_RECORD_TOKENIZER_UNIT_MACROS_SVH
`define CSV_RECORD_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define CSV_TOK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define CSV_TOK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/csv_tok_pkg.sv =====
// Shared types, codes and helpers for the CSV record tokenizer.
// No dependencies; every RTL module imports this package.
package csv_tok_pkg;

  // Fixed characters of the format.
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  // Configuration register file.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0]  REG_SEPARATOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_QUOTE       = 2'd1;
  localparam logic [CFG_DATA_W-1:0] SEPARATOR_RESET = 7'd44;
  localparam logic [CFG_DATA_W-1:0] QUOTE_RESET     = 7'd34;

  // Parser modes.
  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_UNQ    = 3'd1,
    MODE_QUOTED = 3'd2,
    MODE_QESC   = 3'd3,
    MODE_SKIP   = 3'd4
  } mode_t;

  // What a word closes.
  typedef enum logic [1:0] {
    CL_NONE   = 2'd0,
    CL_FIELD  = 2'd1,
    CL_RECORD = 2'd2,
    CL_ERROR  = 2'd3
  } close_t;

  // Input word.
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_stream;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       field_done;
    logic       record_done;
    logic       unclosed_quote;
    logic       last;
  } out_word_t;

  // Up to two results caused by one input word.
  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  r0;
    out_word_t  r1;
  } res_pair_t;

  // Build one result word from its parts.
  function automatic out_word_t make_res(logic has, logic [7:0] b, close_t cl, logic lst);
    out_word_t r;
    r.has_byte       = has;
    r.out_byte       = has ? b : 8'd0;
    r.field_done     = (cl != CL_NONE);
    r.record_done    = (cl == CL_RECORD) || (cl == CL_ERROR);
    r.unclosed_quote = (cl == CL_ERROR);
    r.last           = lst;
    return r;
  endfunction

endpackage

// ===== rtl/csv_tok_core.sv =====
// Parse-mode state machine and per-byte result decode of the CSV tokenizer.
// Depends on csv_tok_pkg and the assertion macro header.
`include "csv_record_tokenizer_unit_macros.svh"

module csv_tok_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  csv_tok_pkg::in_word_t item,
  input  logic [6:0]            sep_char,
  input  logic [6:0]            quo_char,
  output csv_tok_pkg::res_pair_t res
);
  import csv_tok_pkg::*;

  mode_t      mode_r, mode_nxt, mode_byte;
  logic [7:0] c;
  logic       eos, is_sep, is_quo, is_brk;
  mode_t      brk_mode;
  logic [1:0] nb;
  close_t     cl_byte, cl;

  assign c        = item.char_byte;
  assign eos      = item.end_of_stream;
  assign is_sep   = (c == {1'b0, sep_char});
  assign is_quo   = (c == {1'b0, quo_char});
  assign is_brk   = (c == CH_LF) || (c == CH_CR);
  assign brk_mode = (c == CH_CR) ? MODE_SKIP : MODE_START;

  // Next mode: effect of the byte, then end of stream forces a fresh start.
  always_comb begin
    mode_byte = mode_r;
    unique case (mode_r)
      MODE_START: begin
        if (is_sep)      mode_byte = MODE_START;
        else if (is_brk) mode_byte = brk_mode;
        else if (is_quo) mode_byte = MODE_QUOTED;
        else             mode_byte = MODE_UNQ;
      end
      MODE_UNQ: begin
        if (is_sep)      mode_byte = MODE_START;
        else if (is_brk) mode_byte = brk_mode;
      end
      MODE_QUOTED: begin
        if (is_quo) mode_byte = MODE_QESC;
      end
      MODE_QESC: begin
        if (is_sep)      mode_byte = MODE_START;
        else if (is_brk) mode_byte = brk_mode;
        else             mode_byte = MODE_QUOTED;
      end
      MODE_SKIP: begin
        mode_byte = (c == CH_LF) ? MODE_START : MODE_SKIP;
      end
      default: mode_byte = MODE_START;
    endcase
    mode_nxt = eos ? MODE_START : mode_byte;
  end

  // Outputs: how many content bytes and which close mark this byte causes.
  always_comb begin
    nb      = 2'd0;
    cl_byte = CL_NONE;
    unique case (mode_r)
      MODE_START: begin
        if (is_sep)       cl_byte = CL_FIELD;
        else if (is_brk)  cl_byte = CL_RECORD;
        else if (!is_quo) nb = 2'd1;
      end
      MODE_UNQ: begin
        if (is_sep)      cl_byte = CL_FIELD;
        else if (is_brk) cl_byte = CL_RECORD;
        else             nb = 2'd1;
      end
      MODE_QUOTED: begin
        if (!is_quo) nb = 2'd1;
      end
      MODE_QESC: begin
        if (is_sep)      cl_byte = CL_FIELD;
        else if (is_brk) cl_byte = CL_RECORD;
        else if (is_quo) nb = 2'd1;
        else             nb = 2'd2;
      end
      default: nb = 2'd0;
    endcase

    // End of stream closes whatever is still open.
    cl = cl_byte;
    if (eos) begin
      if (mode_byte == MODE_QUOTED) cl = CL_ERROR;
      else if (mode_byte == MODE_UNQ || mode_byte == MODE_QESC || cl_byte == CL_FIELD)
        cl = CL_RECORD;
    end

    // Close marks ride on the last byte, or go out alone.
    res.r1 = make_res(1'b0, 8'd0, CL_NONE, 1'b0);
    case (nb)
      2'd2: begin
        res.cnt = 2'd2;
        res.r0  = make_res(1'b1, {1'b0, quo_char}, CL_NONE, 1'b0);
        res.r1  = make_res(1'b1, c, cl, 1'b1);
      end
      2'd1: begin
        res.cnt = 2'd1;
        res.r0  = make_res(1'b1, c, cl, 1'b1);
      end
      default: begin
        res.cnt = (cl != CL_NONE) ? 2'd1 : 2'd0;
        res.r0  = make_res(1'b0, 8'd0, cl, 1'b1);
      end
    endcase
  end

  // Mode register advances once per word taken from the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_START;
    end else if (step) begin
      mode_r <= mode_nxt;
    end
  end

  `CSV_TOK_ASSERT_NXT(a_eos_restart, step && eos, mode_r == MODE_START, "no restart after end of stream")
  `CSV_TOK_ASSERT_IMP(a_pair_quoted, step && res.cnt == 2'd2, mode_byte == MODE_QUOTED, "byte pair outside quotes")
  `CSV_TOK_ASSERT_NXT(a_mode_hold, !step, mode_r == $past(mode_r), "mode moved without a word")

endmodule

// ===== rtl/csv_tok_outbuf.sv =====
// Two-entry result buffer of the CSV tokenizer: takes a result pair, sends words in order.
// Depends on csv_tok_pkg and the assertion macro header.
`include "csv_record_tokenizer_unit_macros.svh"

module csv_tok_outbuf (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   take,
  input  csv_tok_pkg::res_pair_t res,
  output logic                   can_take,
  output logic                   out_valid,
  input  logic                   out_ready,
  output csv_tok_pkg::out_word_t out_data
);
  import csv_tok_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  out_word_t  e0_r, e1_r;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = e0_r;
  assign pop       = out_valid && out_ready;
  // A new pair fits only when the buffer is empty or its one word leaves this cycle.
  assign can_take  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);

  // Fill count.
  always_comb begin
    if (take)     cnt_nxt = res.cnt;
    else if (pop) cnt_nxt = cnt_r - 2'd1;
    else          cnt_nxt = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Entries: load a fresh pair, or shift the second word to the head.
  always_ff @(posedge clk) begin
    if (take) begin
      e0_r <= res.r0;
      e1_r <= res.r1;
    end else if (pop) begin
      e0_r <= e1_r;
    end
  end

  `CSV_TOK_ASSERT_IMP(a_head_not_last, out_valid && !out_data.last, cnt_r == 2'd2, "non-final word without a follower")
  `CSV_TOK_ASSERT_IMP(a_tail_last, cnt_r == 2'd2, e1_r.last, "second word not final")
  `CSV_TOK_ASSERT_NXT(a_empty_take, take && res.cnt == 2'd0, cnt_r == 2'd0, "stale word after empty take")
  `CSV_TOK_ASSERT_IMP(a_full_blocks, cnt_r == 2'd2, !can_take, "take offered while full")

endmodule

// ===== rtl/csv_record_tokenizer_unit.sv =====
// CSV record tokenizer: stream bytes in, field bytes and close marks out.
// Accepted bytes pass through the input stage register, then the result buffer registers.
// Throughput: one byte per cycle while out_ready stays high; a byte that yields two words
// (lone quote plus byte) holds input until its first word leaves the single output port.
// Reset (synchronous, rst_n low): parser to record start, separator ',' and quote '"'.
// Depends on csv_tok_pkg, csv_tok_core and csv_tok_outbuf.
module csv_record_tokenizer_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  csv_tok_pkg::in_word_t                 in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output csv_tok_pkg::out_word_t                out_data,
  input  logic                                  cfg_we,
  input  logic [csv_tok_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csv_tok_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import csv_tok_pkg::*;

  logic [CFG_DATA_W-1:0] sep_r, quo_r;
  logic                  s_valid_r, s_valid_nxt;
  in_word_t              s_item_r;
  logic                  can_take, take, in_fire;
  res_pair_t             res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEPARATOR_RESET;
      quo_r <= QUOTE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEPARATOR: sep_r <= cfg_wdata;
        REG_QUOTE:     quo_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input stage: refills in the same cycle that its word moves on.
  assign take     = s_valid_r && can_take;
  assign in_ready = !s_valid_r || take;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (in_fire)   s_valid_nxt = 1'b1;
    else if (take) s_valid_nxt = 1'b0;
    else           s_valid_nxt = s_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else begin
      s_valid_r <= s_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s_item_r <= in_data;
    end
  end

  // Parser.
  csv_tok_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (take),
    .item     (s_item_r),
    .sep_char (sep_r),
    .quo_char (quo_r),
    .res      (res)
  );

  // Result buffer.
  csv_tok_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
